FILE: sv/uat_pkg.sv
package uat_pkg;

  localparam int UID_W = 32;

  // Request codes; the unused code behaves as a check.
  localparam logic [1:0] REQ_CHECK  = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_PRESENT   = 3'd2;
  localparam logic [2:0] ST_MASTER    = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  localparam logic [UID_W-1:0] MASTER_RESET = {8'hB3, 8'h1B, 8'h80, 8'h1B};

  typedef struct packed {
    logic load;      // latch the incoming word and clear the search
    logic mst_hit;   // record a match against the master UID
    logic rd;        // read the member at the pointer
    logic cmp;       // compare read data, record hit or advance pointer
    logic decide;    // form the result and apply an insert
    logic rd_next;   // read the member above the pointer
    logic sh_wr;     // move the read member down one place
    logic sh_done;   // compaction finished, drop the count
    logic publish;   // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic master_eq;
    logic ptr_end;
    logic rd_eq;
    logic shift_go;
    logic shift_end;
    logic out_free;
  } stat_t;

endpackage

FILE: sv/uat_req_if.sv
interface uat_req_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 req_type;
  logic [uat_pkg::UID_W-1:0]  card_uid;

  modport source (output valid, output req_type, output card_uid, input ready);
  modport sink   (input valid, input req_type, input card_uid, output ready);
endinterface

FILE: sv/uat_res_if.sv
interface uat_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [4:0] match_index;
  logic       is_master;
  logic [4:0] member_total;

  modport source (output valid, output status, output match_index, output is_master,
                  output member_total, input ready);
  modport sink   (input valid, input status, input match_index, input is_master,
                  input member_total, output ready);
endinterface

FILE: sv/uat_ctrl.sv
module uat_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  uat_pkg::stat_t stat,
  output uat_pkg::cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SEARCH  = 7'b0000010,
    S_COMPARE = 7'b0000100,
    S_DECIDE  = 7'b0001000,
    S_SH_RD   = 7'b0010000,
    S_SH_WR   = 7'b0100000,
    S_PUBLISH = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        // The master UID always wins over a stored member with the same value.
        if (stat.master_eq) begin
          cmd.mst_hit = 1'b1;
          state_nxt   = S_DECIDE;
        end else if (stat.ptr_end) begin
          state_nxt = S_DECIDE;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_COMPARE;
        end
      end
      S_COMPARE: begin
        cmd.cmp   = 1'b1;
        state_nxt = stat.rd_eq ? S_DECIDE : S_SEARCH;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = stat.shift_go ? S_SH_RD : S_PUBLISH;
      end
      S_SH_RD: begin
        if (stat.shift_end) begin
          cmd.sh_done = 1'b1;
          state_nxt   = S_PUBLISH;
        end else begin
          cmd.rd_next = 1'b1;
          state_nxt   = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.sh_wr = 1'b1;
        state_nxt = S_SH_RD;
      end
      S_PUBLISH: begin
        if (stat.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/uat_dpath.sv
module uat_dpath #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [uat_pkg::UID_W-1:0] cfg_wdata,
  input  logic [1:0]                in_req_type,
  input  logic [uat_pkg::UID_W-1:0] in_card_uid,
  input  uat_pkg::cmd_t             cmd,
  output uat_pkg::stat_t            stat,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [2:0]                out_status,
  output logic [4:0]                out_match_index,
  output logic                      out_is_master,
  output logic [4:0]                out_member_total
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [uat_pkg::UID_W-1:0] mem [TABLE_DEPTH];

  logic [uat_pkg::UID_W-1:0] master_r, uid_r, rd_data_r;
  logic [1:0]                req_r;
  logic [CW-1:0]             count_r, ptr_r, hit_pos_r, res_index_r;
  logic                      hit_r, res_master_r;
  logic [2:0]                res_status_r;
  logic                      out_valid_r, out_master_r;
  logic [2:0]                out_status_r;
  logic [4:0]                out_index_r, out_total_r;

  logic [CW-1:0]             ptr_inc;
  logic                      full, ins_ok, master_eq;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr, mem_raddr;
  logic [uat_pkg::UID_W-1:0] mem_wdata;

  assign ptr_inc   = ptr_r + CW'(1);
  assign full      = (count_r == CW'(TABLE_DEPTH));
  assign master_eq = (uid_r == master_r);
  assign ins_ok    = cmd.decide && (req_r == uat_pkg::REQ_INSERT) && !hit_r && !full;

  assign stat.master_eq = master_eq;
  assign stat.ptr_end   = (ptr_r >= count_r);
  assign stat.rd_eq     = (rd_data_r == uid_r);
  assign stat.shift_go  = (req_r == uat_pkg::REQ_REMOVE) && hit_r && (hit_pos_r != '0);
  assign stat.shift_end = (ptr_inc >= count_r);
  assign stat.out_free  = !out_valid_r || out_ready;

  // An insert appends at the count; compaction writes one place below the read.
  always_comb begin
    mem_we    = ins_ok || cmd.sh_wr;
    mem_waddr = ins_ok ? count_r[AW-1:0] : ptr_r[AW-1:0];
    mem_wdata = ins_ok ? uid_r : rd_data_r;
    mem_raddr = cmd.rd_next ? ptr_inc[AW-1:0] : ptr_r[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd || cmd.rd_next) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_r <= uat_pkg::MASTER_RESET;
    end else if (cfg_we) begin
      master_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ins_ok) begin
      count_r <= count_r + CW'(1);
    end else if (cmd.sh_done) begin
      count_r <= count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      uid_r     <= in_card_uid;
      req_r     <= in_req_type;
      ptr_r     <= '0;
      hit_r     <= 1'b0;
      hit_pos_r <= '0;
    end
    if (cmd.mst_hit) begin
      hit_r     <= 1'b1;
      hit_pos_r <= '0;
    end
    if (cmd.cmp) begin
      if (rd_data_r == uid_r) begin
        hit_r     <= 1'b1;
        hit_pos_r <= ptr_inc;
      end else begin
        ptr_r <= ptr_inc;
      end
    end
    if (cmd.sh_wr) begin
      ptr_r <= ptr_inc;
    end
    if (cmd.decide) begin
      res_master_r <= master_eq;
      case (req_r)
        uat_pkg::REQ_INSERT: begin
          if (hit_r) begin
            res_status_r <= uat_pkg::ST_PRESENT;
            res_index_r  <= hit_pos_r;
          end else if (full) begin
            res_status_r <= uat_pkg::ST_FULL;
            res_index_r  <= '0;
          end else begin
            res_status_r <= uat_pkg::ST_OK;
            res_index_r  <= count_r + CW'(1);
          end
        end
        uat_pkg::REQ_REMOVE: begin
          if (!hit_r) begin
            res_status_r <= uat_pkg::ST_NOT_FOUND;
            res_index_r  <= '0;
          end else if (hit_pos_r == '0) begin
            res_status_r <= uat_pkg::ST_MASTER;
            res_index_r  <= '0;
          end else begin
            res_status_r <= uat_pkg::ST_OK;
            res_index_r  <= hit_pos_r;
            ptr_r        <= hit_pos_r - CW'(1);
          end
        end
        default: begin
          res_status_r <= hit_r ? uat_pkg::ST_OK : uat_pkg::ST_NOT_FOUND;
          res_index_r  <= hit_r ? hit_pos_r : '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_status_r <= res_status_r;
      out_index_r  <= 5'(res_index_r);
      out_master_r <= res_master_r;
      out_total_r  <= 5'(count_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_match_index  = out_index_r;
  assign out_is_master    = out_master_r;
  assign out_member_total = out_total_r;

endmodule

FILE: sv/uid_allowlist_table_core.sv
// Channel   Direction  Word
// in_req    sink       req_type[1:0], card_uid[31:0]
// out_res   source     status[2:0], match_index[4:0], is_master, member_total[4:0]
// cfg_*     write      cfg_we, cfg_wdata[31:0] (master UID)
//
// A word is taken only when the sequencer is idle. The search reads one member at a time from
// a single-port table, each read followed by a compare, until a hit or the end of the list;
// the master UID is checked before every read, so a hit on it ends the search before any read.
// A remove of a member other than the master then compacts the list, moving later members down.
// A finished result waits in the output register while the next word is accepted, and the
// sequencer holds its next result until that register is free.
// Reset restores the master UID and empties the list; table contents need no clearing.
module uid_allowlist_table_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [uat_pkg::UID_W-1:0] cfg_wdata,
  uat_req_if.sink                   in_req,
  uat_res_if.source                 out_res
);

  uat_pkg::cmd_t  cmd;
  uat_pkg::stat_t stat;

  uat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  uat_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_req_type      (in_req.req_type),
    .in_card_uid      (in_req.card_uid),
    .cmd              (cmd),
    .stat             (stat),
    .out_ready        (out_res.ready),
    .out_valid        (out_res.valid),
    .out_status       (out_res.status),
    .out_match_index  (out_res.match_index),
    .out_is_master    (out_res.is_master),
    .out_member_total (out_res.member_total)
  );

endmodule

FILE: sv/uat_checker.sv
module uat_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic [4:0] out_match_index,
  input logic       out_is_master,
  input logic [4:0] out_member_total
);

  // A word that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_match_index)
      && $stable(out_is_master) && $stable(out_member_total))
    else $error("stalled result word changed");

  // Only one request is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in progress");

  a_not_found_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == uat_pkg::ST_NOT_FOUND |-> out_match_index == 5'd0)
    else $error("not-found result carries a non-zero index");

  // The master is searched first, so its UID can only ever resolve to entry 0.
  a_master_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_master |-> out_match_index == 5'd0
      && out_status != uat_pkg::ST_NOT_FOUND)
    else $error("master UID resolved to a member entry");

endmodule

bind uid_allowlist_table_core uat_checker u_uat_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_req.valid),
  .in_ready         (in_req.ready),
  .out_valid        (out_res.valid),
  .out_ready        (out_res.ready),
  .out_status       (out_res.status),
  .out_match_index  (out_res.match_index),
  .out_is_master    (out_res.is_master),
  .out_member_total (out_res.member_total)
);

FILE: verif/uat_checker.sv
module uat_tb_checker #(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [uat_pkg::UID_W-1:0] cfg_wdata,
  uat_req_if                        req_ch,
  uat_res_if                        res_ch,
  output int unsigned               fail_count,
  output int unsigned               pending,
  output int unsigned               checked_total,
  output int unsigned               full_total,
  output int unsigned               compact_total
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] index;
    logic       is_master;
    logic [4:0] total;
  } answer_t;

  logic [uat_pkg::UID_W-1:0] master_uid = uat_pkg::MASTER_RESET;
  logic [uat_pkg::UID_W-1:0] roster [DEPTH];
  int                        roster_len = 0;
  answer_t                   owed [$];

  task automatic report_mismatch(input string what);
    if (fail_count < 200) begin
      $display("%0t ns: result word %0d: %s", $time, checked_total, what);
    end
    fail_count++;
  endtask

  // Returns 0 for the master, k+1 for member k, or -1 when the UID is unknown.
  function automatic int find_slot(input logic [uat_pkg::UID_W-1:0] uid);
    if (uid == master_uid) return 0;
    for (int k = 0; k < roster_len; k++) begin
      if (roster[k] == uid) return k + 1;
    end
    return -1;
  endfunction

  function automatic answer_t apply_request(input logic [1:0] kind,
                                            input logic [uat_pkg::UID_W-1:0] uid);
    int      slot;
    answer_t ans;
    slot = find_slot(uid);
    ans  = '0;
    if (kind == uat_pkg::REQ_INSERT) begin
      if (slot >= 0) begin
        ans.status = uat_pkg::ST_PRESENT;
        ans.index  = 5'(slot);
      end else if (roster_len >= DEPTH) begin
        ans.status = uat_pkg::ST_FULL;
        full_total++;
      end else begin
        roster[roster_len] = uid;
        roster_len++;
        ans.status = uat_pkg::ST_OK;
        ans.index  = 5'(roster_len);
      end
    end else if (kind == uat_pkg::REQ_REMOVE) begin
      if (slot < 0) begin
        ans.status = uat_pkg::ST_NOT_FOUND;
      end else if (slot == 0) begin
        ans.status = uat_pkg::ST_MASTER;
      end else begin
        // Later members move down one place so that the list stays compact.
        for (int k = slot - 1; k < roster_len - 1; k++) roster[k] = roster[k + 1];
        roster_len--;
        ans.status = uat_pkg::ST_OK;
        ans.index  = 5'(slot);
        compact_total++;
      end
    end else if (slot < 0) begin
      ans.status = uat_pkg::ST_NOT_FOUND;
    end else begin
      ans.status = uat_pkg::ST_OK;
      ans.index  = 5'(slot);
    end
    ans.is_master = (uid == master_uid);
    ans.total     = 5'(roster_len);
    return ans;
  endfunction

  always @(posedge clk) begin : watch
    answer_t got;
    answer_t want;
    if (!rst_n) begin
      master_uid = uat_pkg::MASTER_RESET;
      roster_len = 0;
      owed.delete();
    end else begin
      if (cfg_we) master_uid = cfg_wdata;
      if (res_ch.valid && res_ch.ready) begin
        got.status    = res_ch.status;
        got.index     = res_ch.match_index;
        got.is_master = res_ch.is_master;
        got.total     = res_ch.member_total;
        checked_total++;
        if (owed.size() == 0) begin
          report_mismatch("arrived with no request outstanding");
        end else begin
          want = owed.pop_front();
          if (got.status != want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
          if (got.index != want.index)
            report_mismatch($sformatf("match_index %0d, expected %0d", got.index, want.index));
          if (got.is_master != want.is_master)
            report_mismatch($sformatf("is_master %0d, expected %0d",
                                      got.is_master, want.is_master));
          if (got.total != want.total)
            report_mismatch($sformatf("member_total %0d, expected %0d", got.total, want.total));
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        owed.push_back(apply_request(req_ch.req_type, req_ch.card_uid));
      end
    end
    pending <= owed.size();
  end

endmodule

FILE: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         DEPTH       = 16;
  localparam logic [1:0] REQ_SPARE   = 2'd3;
  localparam int         POOL_SIZE   = 24;
  localparam int         PHASES      = 8;
  localparam int         PHASE_WORDS = 205;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [uat_pkg::UID_W-1:0] cfg_wdata;
  int unsigned               fail_count;
  int unsigned               pending;
  int unsigned               checked_total;
  int unsigned               full_total;
  int unsigned               compact_total;
  int unsigned               words_sent;
  bit                        idle_on = 1'b1;
  logic [uat_pkg::UID_W-1:0] master_now;
  logic [uat_pkg::UID_W-1:0] uid_pool [POOL_SIZE];

  uat_req_if req_if ();
  uat_res_if res_if ();

  uid_allowlist_table_core #(.TABLE_DEPTH(DEPTH)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_req   (req_if),
    .out_res  (res_if)
  );

  uat_tb_checker #(.DEPTH(DEPTH)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .req_ch       (req_if),
    .res_ch       (res_if),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked_total(checked_total),
    .full_total   (full_total),
    .compact_total(compact_total)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("Timed out waiting for the block to answer");
    $display("Test completed with failures");
    $finish;
  end

  // Result side: a random stall before each word, none while idling is switched off.
  initial begin
    int unsigned stall;
    res_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = idle_on ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
    end
  end

  task automatic send_word(input logic [1:0] kind, input logic [uat_pkg::UID_W-1:0] uid);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.card_uid <= uid;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_master(input logic [uat_pkg::UID_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    master_now  = value;
  endtask

  // Mostly UIDs from a small pool, so that hits, duplicates and a full table are common.
  function automatic logic [uat_pkg::UID_W-1:0] pick_uid();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return uid_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (roll < 85) return master_now;
    return $urandom;
  endfunction

  function automatic logic [1:0] pick_kind(input bit filling);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return REQ_SPARE;
    if (roll < (filling ? 60 : 30)) return uat_pkg::REQ_INSERT;
    if (roll < (filling ? 80 : 75)) return uat_pkg::REQ_REMOVE;
    return uat_pkg::REQ_CHECK;
  endfunction

  initial begin
    logic [uat_pkg::UID_W-1:0] next_master;
    int unsigned               hold_at;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    req_if.valid    <= 1'b0;
    req_if.req_type <= uat_pkg::REQ_CHECK;
    req_if.card_uid <= '0;
    words_sent  = 0;
    master_now  = uat_pkg::MASTER_RESET;
    uid_pool[0] = '0;
    uid_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) uid_pool[i] = $urandom;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_word(uat_pkg::REQ_CHECK, uat_pkg::MASTER_RESET);
    send_word(uat_pkg::REQ_CHECK, 32'h0000_0000);
    send_word(uat_pkg::REQ_REMOVE, uat_pkg::MASTER_RESET);
    send_word(uat_pkg::REQ_REMOVE, 32'h1234_5678);
    send_word(uat_pkg::REQ_INSERT, uat_pkg::MASTER_RESET);
    send_word(uat_pkg::REQ_INSERT, 32'h0000_0000);
    send_word(uat_pkg::REQ_INSERT, 32'hFFFF_FFFF);
    send_word(uat_pkg::REQ_INSERT, 32'h5A5A_5A5A);
    send_word(uat_pkg::REQ_INSERT, 32'hA5A5_A5A5);
    send_word(uat_pkg::REQ_INSERT, 32'h0000_0000);
    send_word(uat_pkg::REQ_CHECK, 32'hFFFF_FFFF);
    send_word(REQ_SPARE, 32'hFFFF_FFFF);
    send_word(REQ_SPARE, 32'h1357_2468);
    send_word(uat_pkg::REQ_REMOVE, 32'h0000_0000);
    send_word(uat_pkg::REQ_CHECK, 32'hA5A5_A5A5);
    send_word(uat_pkg::REQ_REMOVE, 32'hA5A5_A5A5);
    send_word(uat_pkg::REQ_REMOVE, 32'h0000_0000);
    // A stored member becomes the master: it is hidden from check and remove.
    write_master(32'hFFFF_FFFF);
    send_word(uat_pkg::REQ_CHECK, 32'hFFFF_FFFF);
    send_word(uat_pkg::REQ_REMOVE, 32'hFFFF_FFFF);
    send_word(uat_pkg::REQ_INSERT, 32'hFFFF_FFFF);
    send_word(uat_pkg::REQ_CHECK, uat_pkg::MASTER_RESET);
    write_master(32'h0000_0000);
    send_word(uat_pkg::REQ_CHECK, 32'h0000_0000);
    send_word(uat_pkg::REQ_CHECK, 32'hFFFF_FFFF);

    // Even phases lean towards inserts and fill the table, odd ones drain it.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       next_master = uat_pkg::MASTER_RESET;
        1:       next_master = '1;
        2, 5:    next_master = uid_pool[$urandom_range(2, POOL_SIZE - 1)];
        4:       next_master = '0;
        default: next_master = $urandom;
      endcase
      write_master(next_master);
      idle_on = (p != 2) && (p != 5);
      hold_at = $urandom_range(20, PHASE_WORDS - 20);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n == hold_at) drain_results();
        send_word(pick_kind(p % 2 == 0), pick_uid());
      end
    end

    drain_results();
    repeat (80) @(posedge clk);
    $display("Sent %0d request words of all four codes under the reset master and %0d %s",
             words_sent, PHASES + 2, "written ones.");
    $display("Checked %0d result words, including %0d table-full refusals and %0d compactions.",
             checked_total, full_total, compact_total);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
